@@ rtl/pfxu_pkg.sv @@
// Shared types, opcodes and constants of the fixed-point execution unit.
package pfxu_pkg;

    localparam int REG_COUNT_DEF = 32;
    localparam int WORD_WIDTH_DEF = 64;

    typedef enum logic [5:0] {
        OP_ADD = 6'd0, OP_ADDC = 6'd1, OP_ADDE = 6'd2, OP_ADDI = 6'd3,
        OP_ADDIC = 6'd4, OP_ADDIS = 6'd5, OP_ADDME = 6'd6, OP_ADDZE = 6'd7,
        OP_ANDI = 6'd8, OP_ANDIS = 6'd9, OP_AND = 6'd10, OP_ANDC = 6'd11,
        OP_EQV = 6'd12, OP_EXTSB = 6'd13, OP_EXTSH = 6'd14, OP_EXTSW = 6'd15,
        OP_CNTLZ = 6'd16, OP_MCRF = 6'd17, OP_CMP = 6'd18, OP_CMPI = 6'd19,
        OP_CMPL = 6'd20, OP_CMPLI = 6'd21, OP_DIVW = 6'd22, OP_DIVWU = 6'd23,
        OP_DIVD = 6'd24, OP_DIVDU = 6'd25, OP_CRAND = 6'd26, OP_CRANDC = 6'd27,
        OP_CREQV = 6'd28, OP_CRNAND = 6'd29, OP_CRNOR = 6'd30, OP_CROR = 6'd31,
        OP_CRORC = 6'd32, OP_CRXOR = 6'd33
    } t_opcode;

    localparam logic [3:0] FLD_LT = 4'b1000;
    localparam logic [3:0] FLD_GT = 4'b0100;
    localparam logic [3:0] FLD_EQ = 4'b0010;

    typedef struct packed {
        logic [5:0]  opcode;
        logic [4:0]  dest_index;
        logic [4:0]  src_a_index;
        logic [4:0]  src_b_index;
        logic signed [15:0] immediate;
        logic        overflow_enable;
        logic        record_enable;
        logic        long_compare;
    } t_in_word;

    typedef struct packed {
        logic [63:0] result_value;
        logic        writes_register;
        logic [4:0]  written_index;
        logic [31:0] condition_word;
        logic        carry_flag;
        logic        overflow_flag;
        logic        sticky_overflow;
    } t_out_word;

endpackage

@@ rtl/pfxu_front.sv @@
// Front end: input queue slot that holds one decoded instruction word.
module pfxu_front
    import pfxu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    output logic     o_full,
    input  t_in_word i_word,
    input  logic     i_take,
    output logic     o_valid,
    output t_in_word o_word
);
    logic     r_valid;
    t_in_word r_word;

    assign o_full  = r_valid && !i_take;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push && !o_full) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // load when the slot frees or is empty
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_word <= i_word;
        end
    end
endmodule

@@ rtl/pfxu_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
module pfxu_div
    import pfxu_pkg::*;
#(
    parameter int W = WORD_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quo
);
    localparam int CW = $clog2(W + 1);
    logic [W-1:0]  r_quo, r_den;
    logic [W:0]    r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [W:0]    w_sh, w_diff;

    assign w_sh   = {r_rem[W-1:0], r_quo[W-1]};
    assign w_diff = w_sh - {1'b0, r_den};
    assign o_done = r_busy && (r_cnt == CW'(1));
    assign o_quo  = {r_quo[W-2:0], !w_diff[W]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_cnt <= CW'(W);
        end else if (r_busy) begin
            r_rem <= w_diff[W] ? w_sh : w_diff;
            r_quo <= {r_quo[W-2:0], !w_diff[W]};
            r_cnt <= r_cnt - CW'(1);
        end
    end
endmodule

@@ rtl/pfxu_back.sv @@
// Back end: register file, CR/XER state, execution and result register.
module pfxu_back
    import pfxu_pkg::*;
#(
    parameter int REGISTER_COUNT = REG_COUNT_DEF,
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_word  i_word,
    output logic      o_take,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_word o_word
);
    localparam int W  = WORD_WIDTH;
    localparam int IW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
    localparam int CW = $clog2(W + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001, S_READ = 3'b010, S_DIV = 3'b100
    } t_state;

    t_state        r_state;
    logic [W-1:0]  r_gpr [REGISTER_COUNT];
    logic [REGISTER_COUNT-1:0] r_vld;
    logic [31:0]   r_cr;
    logic          r_ca, r_ov, r_so;
    t_in_word      r_ins;
    logic [W-1:0]  r_a, r_b;
    logic          r_out_v;
    t_out_word     r_out;

    // index wrap
    function automatic logic [IW-1:0] wrap(input logic [4:0] idx);
        logic [5:0] t;
        t = {1'b0, idx};
        if (t >= 6'(REGISTER_COUNT)) t = t - 6'(REGISTER_COUNT);
        if (t >= 6'(REGISTER_COUNT)) t = t - 6'(REGISTER_COUNT);
        if (t >= 6'(REGISTER_COUNT)) t = t - 6'(REGISTER_COUNT);
        return t[IW-1:0];
    endfunction

    logic [IW-1:0] w_ia, w_ib, w_it;
    assign w_ia = wrap(i_word.src_a_index);
    assign w_ib = wrap(i_word.src_b_index);
    assign w_it = wrap(r_ins.dest_index);

    assign o_take  = (r_state == S_IDLE) && i_valid;
    assign o_empty = !r_out_v;
    assign o_word  = r_out;

    // operand read: flops, valid bits cleared on reset
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_ins <= i_word;
            r_a   <= r_vld[w_ia] ? r_gpr[w_ia] : '0;
            r_b   <= r_vld[w_ib] ? r_gpr[w_ib] : '0;
        end
    end

    // divider operand prep
    logic          w_dword, w_signed, w_neg, w_ovdiv;
    logic [W-1:0]  w_na, w_nb, w_ua, w_ub, w_quo, w_qfix;
    logic          w_div_done, w_div_start;
    logic [W-1:0]  w_a32, w_b32;
    assign w_a32 = W'(r_a[31:0]);
    assign w_b32 = W'(r_b[31:0]);
    always_comb begin
        w_dword  = (r_ins.opcode == OP_DIVD) || (r_ins.opcode == OP_DIVDU);
        w_signed = (r_ins.opcode == OP_DIVD) || (r_ins.opcode == OP_DIVW);
        w_na = w_dword ? r_a : w_a32;
        w_nb = w_dword ? r_b : w_b32;
        if (w_signed && !w_dword) begin
            w_ua = r_a[31] ? W'(32'(-r_a[31:0])) : w_a32;
            w_ub = r_b[31] ? W'(32'(-r_b[31:0])) : w_b32;
            w_neg = r_a[31] ^ r_b[31];
        end else if (w_signed) begin
            w_ua = r_a[W-1] ? -r_a : r_a;
            w_ub = r_b[W-1] ? -r_b : r_b;
            w_neg = r_a[W-1] ^ r_b[W-1];
        end else begin
            w_ua = w_na;
            w_ub = w_nb;
            w_neg = 1'b0;
        end
        if (w_dword) begin
            w_ovdiv = (r_b == '0) || (w_signed && r_a == {1'b1, {(W-1){1'b0}}}
                      && r_b == '1);
        end else begin
            w_ovdiv = (r_b[31:0] == '0) || (w_signed && r_a[31:0] == 32'h8000_0000
                      && r_b[31:0] == 32'hFFFF_FFFF);
        end
    end
    assign w_div_start = (r_state == S_READ) && (r_ins.opcode >= OP_DIVW)
                         && (r_ins.opcode <= OP_DIVDU);

    pfxu_div #(.W(W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_ua),
        .i_den   (w_ub),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_comb begin
        w_qfix = w_neg ? -w_quo : w_quo;
        if (!w_dword) begin
            w_qfix = w_signed ? W'(signed'(w_qfix[31:0])) : W'(w_qfix[31:0]);
        end
        if (w_ovdiv) w_qfix = '0;
    end

    // combinational execution: result, flags and condition register update
    logic [W-1:0] w_si, w_ui, w_v, w_base;
    logic [W:0]   w_sum;
    logic         w_wr, w_xo, w_rec, w_ov, w_ca, w_ca_upd;
    logic [31:0]  w_cr;
    logic [3:0]   w_fld;
    logic         w_bx, w_by, w_br;
    logic [W-1:0] w_opb;
    logic         w_cin;
    logic [W-1:0] w_ca_a, w_cb_b, w_flip;
    logic [CW-1:0] w_clz;
    logic [W-1:0] w_ovsign;

    always_comb begin
        w_si = W'(signed'(r_ins.immediate));
        w_ui = W'(r_ins.immediate[15:0]);
        w_ovsign = {1'b1, {(W-1){1'b0}}};
        w_opb = r_b;
        w_cin = 1'b0;
        unique case (r_ins.opcode)
            OP_ADDE: w_cin = r_ca;
            OP_ADDIC: w_opb = w_si;
            OP_ADDME: begin w_opb = '1; w_cin = r_ca; end
            OP_ADDZE: begin w_opb = '0; w_cin = r_ca; end
            default: ;
        endcase
        w_sum = {1'b0, r_a} + {1'b0, w_opb} + (W+1)'(w_cin);
        w_base = (r_ins.src_a_index != 5'd0) ? r_a : '0;
        w_clz = '0;
        if (r_ins.long_compare) begin
            for (int i = 0; i < W; i++) if (r_a[i]) w_clz = CW'(W - 1 - i);
            if (r_a == '0) w_clz = CW'(W);
        end else begin
            for (int i = 0; i < 32; i++) if (r_a[i]) w_clz = CW'(31 - i);
            if (r_a[31:0] == '0) w_clz = CW'(32);
        end
        w_ca_a = r_a;
        w_cb_b = r_b;
        w_flip = '0;
        w_fld = '0;
        w_v = '0; w_wr = 1'b0; w_xo = 1'b0; w_rec = 1'b0; w_ov = 1'b0;
        w_ca = r_ca; w_ca_upd = 1'b0;
        w_cr = r_cr;
        w_bx = r_cr[5'd31 - r_ins.src_a_index];
        w_by = r_cr[5'd31 - r_ins.src_b_index];
        w_br = 1'b0;
        unique case (r_ins.opcode)
            OP_ADD, OP_ADDC, OP_ADDE, OP_ADDME, OP_ADDZE: begin
                w_v = w_sum[W-1:0];
                w_ov = |((r_a ^ w_v) & (w_opb ^ w_v) & w_ovsign);
                w_wr = 1'b1; w_xo = 1'b1; w_rec = r_ins.record_enable;
                w_ca_upd = (r_ins.opcode != OP_ADD);
            end
            OP_ADDIC: begin
                w_v = w_sum[W-1:0]; w_wr = 1'b1; w_rec = r_ins.record_enable;
                w_ca_upd = 1'b1;
            end
            OP_ADDI:  begin w_v = w_base + w_si; w_wr = 1'b1; end
            OP_ADDIS: begin w_v = w_base + (w_si << 16); w_wr = 1'b1; end
            OP_ANDI:  begin w_v = r_a & w_ui; w_wr = 1'b1; w_rec = 1'b1; end
            OP_ANDIS: begin w_v = r_a & (w_ui << 16); w_wr = 1'b1; w_rec = 1'b1; end
            OP_AND:   begin w_v = r_a & r_b; w_wr = 1'b1; w_rec = r_ins.record_enable; end
            OP_ANDC:  begin w_v = r_a & ~r_b; w_wr = 1'b1; w_rec = r_ins.record_enable; end
            OP_EQV:   begin w_v = ~(r_a ^ r_b); w_wr = 1'b1; w_rec = r_ins.record_enable; end
            OP_EXTSB: begin
                w_v = W'(signed'(r_a[7:0])); w_wr = 1'b1; w_rec = r_ins.record_enable;
            end
            OP_EXTSH: begin
                w_v = W'(signed'(r_a[15:0])); w_wr = 1'b1; w_rec = r_ins.record_enable;
            end
            OP_EXTSW: begin
                w_v = W'(signed'(r_a[31:0])); w_wr = 1'b1; w_rec = r_ins.record_enable;
            end
            OP_CNTLZ: begin
                w_v = W'(w_clz); w_wr = 1'b1; w_rec = r_ins.record_enable;
            end
            OP_MCRF: begin
                w_fld = r_cr[5'd28 - {r_ins.src_a_index[2:0], 2'b00} +: 4];
                w_cr[5'd28 - {r_ins.dest_index[2:0], 2'b00} +: 4] = w_fld;
            end
            OP_CMP, OP_CMPI, OP_CMPL, OP_CMPLI: begin
                if (r_ins.opcode == OP_CMPI) w_cb_b = w_si;
                if (r_ins.opcode == OP_CMPLI) w_cb_b = w_ui;
                if (!r_ins.long_compare) begin
                    w_ca_a = w_a32;
                    if (r_ins.opcode != OP_CMPLI) w_cb_b = W'(w_cb_b[31:0]);
                end
                if (r_ins.opcode == OP_CMP || r_ins.opcode == OP_CMPI) begin
                    w_flip = r_ins.long_compare ? w_ovsign : W'(32'h8000_0000);
                end
                w_ca_a = w_ca_a ^ w_flip;
                w_cb_b = w_cb_b ^ w_flip;
                w_fld = (w_ca_a < w_cb_b) ? FLD_LT : (w_ca_a > w_cb_b) ? FLD_GT : FLD_EQ;
                w_cr[5'd28 - {r_ins.dest_index[2:0], 2'b00} +: 4] = w_fld | {3'b0, r_so};
            end
            OP_DIVW, OP_DIVWU, OP_DIVD, OP_DIVDU: begin
                w_v = w_qfix; w_ov = w_ovdiv; w_wr = 1'b1; w_xo = 1'b1;
                w_rec = r_ins.record_enable;
            end
            OP_CRAND, OP_CRANDC, OP_CREQV, OP_CRNAND,
            OP_CRNOR, OP_CROR, OP_CRORC, OP_CRXOR: begin
                unique case (r_ins.opcode)
                    OP_CRAND:  w_br = w_bx & w_by;
                    OP_CRANDC: w_br = w_bx & !w_by;
                    OP_CREQV:  w_br = !(w_bx ^ w_by);
                    OP_CRNAND: w_br = !(w_bx & w_by);
                    OP_CRNOR:  w_br = !(w_bx | w_by);
                    OP_CROR:   w_br = w_bx | w_by;
                    OP_CRORC:  w_br = w_bx | !w_by;
                    default:   w_br = w_bx ^ w_by;
                endcase
                w_cr[5'd31 - r_ins.dest_index] = w_br;
            end
            default: ;
        endcase
        if (w_ca_upd) w_ca = w_sum[W];
    end

    logic w_fire, w_so_n, w_ov_n;
    logic [31:0] w_cr_n;
    always_comb begin
        w_fire = ((r_state == S_READ) && !w_div_start) || w_div_done;
        w_ov_n = (w_xo && r_ins.overflow_enable) ? w_ov : r_ov;
        w_so_n = r_so | (w_xo && r_ins.overflow_enable && w_ov);
        w_cr_n = w_cr;
        if (w_rec) begin
            w_cr_n[31:28] = ((w_v == '0) ? FLD_EQ : w_v[W-1] ? FLD_LT : FLD_GT)
                            | {3'b0, w_so_n};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld <= '0;
            r_cr <= '0; r_ca <= 1'b0; r_ov <= 1'b0; r_so <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            // hold the next item until the result register is free
            unique case (r_state)
                S_IDLE: if (o_take) r_state <= S_READ;
                S_READ: if (w_div_start) r_state <= S_DIV;
                        else if (w_fire) r_state <= S_IDLE;
                S_DIV:  if (w_div_done) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
            if (w_fire) begin
                r_cr <= w_cr_n; r_ca <= w_ca; r_ov <= w_ov_n; r_so <= w_so_n;
                if (w_wr) r_vld[w_it] <= 1'b1;
                r_out_v <= 1'b1;
            end else if (i_pop) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // result and register write
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            if (w_wr) r_gpr[w_it] <= w_v;
            r_out.result_value    <= w_wr ? 64'(w_v) : '0;
            r_out.writes_register <= w_wr;
            r_out.written_index   <= w_wr ? 5'(w_it) : '0;
            r_out.condition_word  <= w_cr_n;
            r_out.carry_flag      <= w_ca;
            r_out.overflow_flag   <= w_ov_n;
            r_out.sticky_overflow <= w_so_n;
        end
    end
endmodule

@@ rtl/powerpc_fixed_point_unit.sv @@
// Top level of the fixed-point execution unit: front slot and execute back end.
// A word passes the front slot, then operand read in the back end, then execute into
// the result register; a divide runs its W divider steps between operand read and the result.
// The back end takes a new word only when idle, so it works on one word at a time; a divide
// holds it for operand read and W divider steps before it returns to idle.
// A result register sits at the output; the back end waits while it is still full.
// Reset (synchronous, active low) zeroes the register file via valid bits, CR and XER.
module powerpc_fixed_point_unit
    import pfxu_pkg::*;
#(
    parameter int REGISTER_COUNT = REG_COUNT_DEF,
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_word  i_word,
    output logic      empty,
    input  logic      pop,
    output t_out_word o_word
);
    logic     w_valid, w_take, w_take_ok, w_empty;
    t_in_word w_word;

    pfxu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_word  (i_word),
        .i_take  (w_take_ok),
        .o_valid (w_valid),
        .o_word  (w_word)
    );

    // advance into execute only when the result register will be free
    assign w_take_ok = w_take;

    pfxu_back #(
        .REGISTER_COUNT (REGISTER_COUNT),
        .WORD_WIDTH     (WORD_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid && (w_empty || pop)),
        .i_word  (w_word),
        .o_take  (w_take),
        .o_empty (w_empty),
        .i_pop   (pop),
        .o_word  (o_word)
    );

    assign empty = w_empty;
endmodule

@@ test/powerpc_fixed_point_unit_test.sv @@
// Self-checking testbench for the fixed-point execution unit, with a scoreboard class.
module powerpc_fixed_point_unit_test
    import pfxu_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
    localparam int STALL_LIMIT = 2000;

    // Scoreboard: tracks the architected state and queues the expected words.
    class fxu_scoreboard;
        logic [63:0] gpr [32];
        logic [31:0] cr;
        logic        ca, ov, so;
        t_out_word   pending [$];
        int          errors;

        function new();
            foreach (gpr[i]) gpr[i] = '0;
            cr = '0;
            ca = 0;
            ov = 0;
            so = 0;
            errors = 0;
        endfunction

        function logic [3:0] cmp_field(logic [63:0] a, logic [63:0] b, logic [63:0] flip);
            logic [63:0] x, y;
            x = a ^ flip;
            y = b ^ flip;
            return ((x < y) ? FLD_LT : (x > y) ? FLD_GT : FLD_EQ) | {3'b0, so};
        endfunction

        function void put_field(logic [2:0] n, logic [3:0] f);
            cr[31 - 4 * n -: 4] = f;
        endfunction

        function logic [63:0] clz(logic [63:0] x, int n);
            logic [63:0] c;
            c = 0;
            for (int i = n - 1; i >= 0; i--) begin
                if (x[i]) break;
                c++;
            end
            return c;
        endfunction

        // Signed divide at 64 bits; operands already sign extended.
        function logic [63:0] sdiv(logic [63:0] a, logic [63:0] b);
            logic [63:0] ua, ub, q;
            ua = a[63] ? -a : a;
            ub = b[63] ? -b : b;
            q = ua / ub;
            return (a[63] ^ b[63]) ? -q : q;
        endfunction

        // Note an accepted input word: update state and queue the expected result.
        function void note_input(t_in_word w);
            logic [63:0] a, b, ui, si, v;
            logic [64:0] sum;
            logic        wr, xo, rec, ovr, x, y, r;
            logic [31:0] xa, yb;
            t_out_word   e;
            a = gpr[w.src_a_index];
            b = gpr[w.src_b_index];
            ui = {48'b0, w.immediate};
            si = {{48{w.immediate[15]}}, w.immediate};
            v = 0; wr = 0; xo = 0; rec = 0; ovr = 0; r = 0;
            case (w.opcode)
                OP_ADD, OP_ADDC, OP_ADDE, OP_ADDME, OP_ADDZE: begin
                    logic [63:0] bb;
                    logic        cin;
                    bb = (w.opcode == OP_ADDME) ? ALL_ONES : (w.opcode == OP_ADDZE) ? 64'd0 : b;
                    cin = (w.opcode inside {OP_ADDE, OP_ADDME, OP_ADDZE}) ? ca : 1'b0;
                    sum = a + bb + cin;
                    v = sum[63:0];
                    if (w.opcode != OP_ADD) ca = sum[64];
                    ovr = ((a ^ v) & (bb ^ v) & SIGN64) != 0;
                    wr = 1; xo = 1; rec = w.record_enable;
                end
                OP_ADDI: begin v = (w.src_a_index ? a : 64'd0) + si; wr = 1; end
                OP_ADDIS: begin v = (w.src_a_index ? a : 64'd0) + (si << 16); wr = 1; end
                OP_ADDIC: begin
                    sum = a + si;
                    v = sum[63:0]; ca = sum[64]; wr = 1; rec = w.record_enable;
                end
                OP_ANDI: begin v = a & ui; wr = 1; rec = 1; end
                OP_ANDIS: begin v = a & (ui << 16); wr = 1; rec = 1; end
                OP_AND: begin v = a & b; wr = 1; rec = w.record_enable; end
                OP_ANDC: begin v = a & ~b; wr = 1; rec = w.record_enable; end
                OP_EQV: begin v = ~(a ^ b); wr = 1; rec = w.record_enable; end
                OP_EXTSB: begin v = {{56{a[7]}}, a[7:0]}; wr = 1; rec = w.record_enable; end
                OP_EXTSH: begin v = {{48{a[15]}}, a[15:0]}; wr = 1; rec = w.record_enable; end
                OP_EXTSW: begin v = {{32{a[31]}}, a[31:0]}; wr = 1; rec = w.record_enable; end
                OP_CNTLZ: begin
                    v = w.long_compare ? clz(a, 64) : clz({32'b0, a[31:0]}, 32);
                    wr = 1; rec = w.record_enable;
                end
                OP_MCRF: put_field(w.dest_index[2:0], cr[31 - 4 * w.src_a_index[2:0] -: 4]);
                OP_CMP: put_field(w.dest_index[2:0], w.long_compare ? cmp_field(a, b, SIGN64)
                    : cmp_field(a[31:0], b[31:0], 64'h8000_0000));
                OP_CMPI: put_field(w.dest_index[2:0], w.long_compare ? cmp_field(a, si, SIGN64)
                    : cmp_field(a[31:0], si[31:0], 64'h8000_0000));
                OP_CMPL: put_field(w.dest_index[2:0], w.long_compare ? cmp_field(a, b, 0)
                    : cmp_field(a[31:0], b[31:0], 0));
                OP_CMPLI: put_field(w.dest_index[2:0], w.long_compare ? cmp_field(a, ui, 0)
                    : cmp_field(a[31:0], ui, 0));
                OP_DIVW: begin
                    xa = a[31:0]; yb = b[31:0];
                    ovr = (yb == 0) || (xa == 32'h8000_0000 && yb == 32'hFFFF_FFFF);
                    if (!ovr) begin
                        v = sdiv({{32{xa[31]}}, xa}, {{32{yb[31]}}, yb});
                        v = {{32{v[31]}}, v[31:0]};
                    end
                    wr = 1; xo = 1; rec = w.record_enable;
                end
                OP_DIVWU: begin
                    xa = a[31:0]; yb = b[31:0];
                    ovr = (yb == 0);
                    if (!ovr) v = {32'b0, xa / yb};
                    wr = 1; xo = 1; rec = w.record_enable;
                end
                OP_DIVD: begin
                    ovr = (b == 0) || (a == SIGN64 && b == ALL_ONES);
                    if (!ovr) v = sdiv(a, b);
                    wr = 1; xo = 1; rec = w.record_enable;
                end
                OP_DIVDU: begin
                    ovr = (b == 0);
                    if (!ovr) v = a / b;
                    wr = 1; xo = 1; rec = w.record_enable;
                end
                OP_CRAND, OP_CRANDC, OP_CREQV, OP_CRNAND,
                OP_CRNOR, OP_CROR, OP_CRORC, OP_CRXOR: begin
                    x = cr[31 - w.src_a_index];
                    y = cr[31 - w.src_b_index];
                    case (w.opcode)
                        OP_CRAND: r = x & y;
                        OP_CRANDC: r = x & ~y;
                        OP_CREQV: r = ~(x ^ y);
                        OP_CRNAND: r = ~(x & y);
                        OP_CRNOR: r = ~(x | y);
                        OP_CROR: r = x | y;
                        OP_CRORC: r = x | ~y;
                        default: r = x ^ y;
                    endcase
                    cr[31 - w.dest_index] = r;
                end
                default: ;
            endcase
            if (xo && w.overflow_enable) begin
                ov = ovr;
                if (ovr) so = 1;
            end
            if (wr) gpr[w.dest_index] = v;
            if (rec) put_field(3'd0, ((v == 0) ? FLD_EQ : v[63] ? FLD_LT : FLD_GT) | {3'b0, so});
            e.result_value = wr ? v : 64'd0;
            e.writes_register = wr;
            e.written_index = wr ? w.dest_index : 5'd0;
            e.condition_word = cr;
            e.carry_flag = ca;
            e.overflow_flag = ov;
            e.sticky_overflow = so;
            pending.push_back(e);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch in %s: got %h, want %h at %0t", what, got, want, $time);
            errors++;
        endtask

        // Check a result word against the oldest expectation.
        task check_result(t_out_word g);
            t_out_word e;
            if (pending.size() == 0) begin
                report("unexpected result word", g.result_value, 0);
                return;
            end
            e = pending.pop_front();
            if (g.result_value !== e.result_value)
                report("result_value", g.result_value, e.result_value);
            if (g.writes_register !== e.writes_register)
                report("writes_register", g.writes_register, e.writes_register);
            if (g.written_index !== e.written_index)
                report("written_index", g.written_index, e.written_index);
            if (g.condition_word !== e.condition_word)
                report("condition_word", g.condition_word, e.condition_word);
            if (g.carry_flag !== e.carry_flag) report("carry_flag", g.carry_flag, e.carry_flag);
            if (g.overflow_flag !== e.overflow_flag)
                report("overflow_flag", g.overflow_flag, e.overflow_flag);
            if (g.sticky_overflow !== e.sticky_overflow)
                report("sticky_overflow", g.sticky_overflow, e.sticky_overflow);
        endtask
    endclass

    logic      i_clk = 0;
    logic      i_rst_n = 0;
    logic      push = 0;
    logic      full;
    t_in_word  i_word = '0;
    logic      empty;
    logic      pop = 0;
    t_out_word o_word;

    fxu_scoreboard fxu_model = new();
    bit  stimulus_done = 0;
    bit  calm_mode = 0;      // no random idling on either side while set
    int  hold_off_cycles = 0; // receiver holds pop low for this many cycles
    int  quiet_cycles = 0;

    powerpc_fixed_point_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_word(i_word),
        .empty(empty), .pop(pop), .o_word(o_word)
    );

    always #10 i_clk = ~i_clk;

    // Track accepted words in both directions, and the idle watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) fxu_model.note_input(i_word);
            if (pop && !empty) fxu_model.check_result(o_word);
            if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Receiver: random pop with optional long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) pop <= 0;
        else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            pop <= 0;
        end else pop <= calm_mode || ($urandom_range(99) >= 10);
    end

    function automatic t_in_word random_word();
        t_in_word w;
        int pick;
        w = t_in_word'($bits(t_in_word)'({$urandom, $urandom}));
        pick = $urandom_range(99);
        // Mostly valid opcodes; a few unused ones for noise.
        w.opcode = (pick < 95) ? 6'($urandom_range(OP_CRXOR)) : 6'($urandom_range(63, 34));
        // Bias operands toward a few registers so results feed later instructions.
        if ($urandom_range(3) != 0) begin
            w.src_a_index = 5'($urandom_range(7));
            w.src_b_index = 5'($urandom_range(7));
            w.dest_index = 5'($urandom_range(7));
        end
        // Keep divides rare: they hold the back end for the whole division.
        if (w.opcode inside {OP_DIVW, OP_DIVWU, OP_DIVD, OP_DIVDU} && $urandom_range(2) != 0)
            w.opcode = OP_ADD;
        return w;
    endfunction

    // Offer one word, at times after a random idle gap, and hold it until accepted.
    task send_word(t_in_word w);
        if (!calm_mode && $urandom_range(99) < 10) begin
            push <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        push <= 1;
        i_word <= w;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    function automatic t_in_word make_word(t_opcode op, int rt, int ra, int rb,
                                           logic [15:0] imm, bit oe, bit rc, bit l);
        t_in_word w;
        w.opcode = op;
        w.dest_index = 5'(rt);
        w.src_a_index = 5'(ra);
        w.src_b_index = 5'(rb);
        w.immediate = imm;
        w.overflow_enable = oe;
        w.record_enable = rc;
        w.long_compare = l;
        return w;
    endfunction

    task drain();
        push <= 0;
        @(posedge i_clk);
        while (fxu_model.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed part: build extreme values, then hit every opcode but OP_ADD, with corner cases.
        send_word(make_word(OP_ADDI, 1, 0, 0, 16'h7FFF, 0, 0, 0));
        send_word(make_word(OP_ADDIS, 2, 0, 0, 16'h8000, 0, 0, 0));  // r2 = 0xFFFF_FFFF_8000_0000
        send_word(make_word(OP_ADDI, 3, 0, 0, 16'hFFFF, 0, 0, 0));   // r3 = -1
        send_word(make_word(OP_ADDIS, 4, 0, 0, 16'h8000, 0, 0, 0));
        send_word(make_word(OP_EXTSW, 5, 2, 0, 0, 0, 1, 0));
        send_word(make_word(OP_ADDC, 6, 3, 3, 0, 1, 1, 0));          // carry out
        send_word(make_word(OP_ADDE, 7, 3, 0, 0, 1, 1, 0));
        send_word(make_word(OP_ADDME, 8, 0, 0, 0, 1, 1, 0));
        send_word(make_word(OP_ADDZE, 9, 3, 0, 0, 1, 1, 0));
        send_word(make_word(OP_ADDIC, 10, 3, 0, 16'h0001, 0, 1, 0));
        send_word(make_word(OP_ANDI, 11, 3, 0, 16'hFFFF, 0, 0, 0));
        send_word(make_word(OP_ANDIS, 12, 3, 0, 16'h8000, 0, 0, 0));
        send_word(make_word(OP_AND, 13, 3, 1, 0, 0, 1, 0));
        send_word(make_word(OP_ANDC, 14, 3, 1, 0, 0, 1, 0));
        send_word(make_word(OP_EQV, 15, 3, 0, 0, 0, 1, 0));
        send_word(make_word(OP_EXTSB, 16, 3, 0, 0, 0, 1, 0));
        send_word(make_word(OP_EXTSH, 17, 1, 0, 0, 0, 1, 0));
        send_word(make_word(OP_CNTLZ, 18, 0, 0, 0, 0, 1, 1));         // zero, doubleword
        send_word(make_word(OP_CNTLZ, 19, 0, 0, 0, 0, 0, 0));         // zero, word
        send_word(make_word(OP_CMP, 7, 2, 1, 0, 0, 0, 1));
        send_word(make_word(OP_CMPI, 5, 3, 0, 16'h8000, 0, 0, 0));
        send_word(make_word(OP_CMPLI, 6, 3, 0, 16'hFFFF, 0, 0, 1));
        send_word(make_word(OP_CMPL, 3, 2, 3, 0, 0, 0, 0));
        send_word(make_word(OP_DIVW, 20, 1, 0, 0, 1, 1, 0));          // divide by zero
        send_word(make_word(OP_DIVD, 21, 4, 3, 0, 1, 1, 1));          // doubleword divide by -1
        send_word(make_word(OP_DIVWU, 22, 3, 1, 0, 1, 0, 0));
        send_word(make_word(OP_DIVDU, 23, 3, 1, 0, 0, 1, 0));
        send_word(make_word(OP_MCRF, 1, 7, 0, 0, 0, 0, 0));
        for (int op = OP_CRAND; op <= OP_CRXOR; op++)
            send_word(make_word(t_opcode'(op), $urandom_range(31), $urandom_range(31),
                                $urandom_range(31), 0, 0, 0, 0));

        // Sender pause until everything has come back.
        drain();

        // Random part; a calm stretch with no idling in the middle.
        for (int n = 0; n < 1750; n++) begin
            calm_mode = (n >= 600 && n < 900);
            if (n == 1200) hold_off_cycles = 200; // receiver backs off, block fills
            send_word(random_word());
        end
        calm_mode = 0;
        push <= 0;
        stimulus_done = 1;
    end

    initial begin
        wait (stimulus_done);
        while (fxu_model.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fxu_model.errors == 0 && fxu_model.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
